// ----- hw/rtl/twrtc_pkg.sv -----
// Shared types, request codes and BCD helpers for the three-wire RTC serial master.
// Used by twrtc_core and three_wire_rtc_serial_master; depends on nothing.
`timescale 1ns / 1ps

package twrtc_pkg;

    // Request codes carried in the input tuser field.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [6:0] WRITE_MAX  = 7'd99;
    localparam logic [7:0] READ_INCR  = 8'h01;
    localparam logic [4:0] SEND_BITS_WRITE = 5'd16;
    localparam logic [4:0] SEND_BITS_READ  = 5'd8;
    localparam logic [4:0] RECV_LAST_BIT   = 5'd7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_addr;
        logic [6:0] write_value;
        logic       io_in;
    } t_req;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } t_res;

    // Decimal to BCD with saturation at 99. The tens digit comes from a
    // multiply by 205/2048, which is exact for values up to 99.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [6:0]  s;
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  u;
        s = (v > WRITE_MAX) ? WRITE_MAX : v;
        p = s * 8'd205;
        t = p[14:11];
        u = s - {t, 3'b000} - {2'b00, t, 1'b0};
        return {t, u[3:0]};
    endfunction

    // BCD to decimal as high * 10 + low, also for digits above nine.
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'b0000, b[7:4]};
        lo = {4'b0000, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

endpackage

// ----- hw/rtl/three_wire_rtc_serial_master.sv -----
// Top level of the three-wire RTC serial master: input register, step core, result register.
// Depends on twrtc_pkg and twrtc_core.
`timescale 1ns / 1ps

// Channel   Dir  Beat fields (lowest bit first)
// s_*       in   tdata: reg_addr[7:0], write_value[14:8], io_in[15]; tuser: req_type[1:0]
// m_*       out  tdata: chip_enable, serial_clock, data_out, data_drive, busy_res,
//                       done_res, read_value[13:6], zero[15:14]
//
// Every input beat yields exactly one output beat. A beat is captured in the
// input register, then stepped through the core and written to the output
// register once that register is free or being emptied, so one beat per cycle
// is sustained while m_tready stays high. The transaction state is updated
// together with the result register, as each beat is stepped.
// Reset (synchronous, active low) returns the link to idle with the clock low.
// A stalled output keeps its beat; the input register still takes one more
// beat, after which s_tready drops until the output is taken.
module three_wire_rtc_serial_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reg_addr[7:0], write_value[14:8], io_in[15]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // chip_enable, serial_clock, data_out, data_drive,
                                   // busy_res, done_res, read_value[13:6], zero[15:14]
);

    logic            r_in_valid;
    twrtc_pkg::t_req r_in_req;
    logic            r_out_valid;
    twrtc_pkg::t_res r_out_res;

    logic            advance;
    twrtc_pkg::t_res step_res;

    // The held beat moves on whenever the result register is free or being emptied.
    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    twrtc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_in_req),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; they are qualified by the valid flags.
    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_req.req_type    <= s_tuser;
            r_in_req.reg_addr    <= s_tdata[7:0];
            r_in_req.write_value <= s_tdata[14:8];
            r_in_req.io_in       <= s_tdata[15];
        end
        if (advance) begin
            r_out_res <= step_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00,
                       r_out_res.read_value,
                       r_out_res.done_res,
                       r_out_res.busy_res,
                       r_out_res.data_drive,
                       r_out_res.data_out,
                       r_out_res.serial_clock,
                       r_out_res.chip_enable};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result overwritten while stalled");
    a_advance_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |-> !s_tready)
        else $error("input register accepted while full");
    a_done_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.done_res |-> !step_res.busy_res && !step_res.chip_enable)
        else $error("transaction ended with the link still busy");
`endif

endmodule

// ----- hw/rtl/twrtc_core.sv -----
// Transaction state and single-pass step logic of the three-wire RTC serial master.
// Depends on twrtc_pkg.
`timescale 1ns / 1ps

module twrtc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  twrtc_pkg::t_req i_req,
    output twrtc_pkg::t_res o_res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_RECV = 2'd2
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [4:0]  r_bit_index,  n_bit_index;
    logic [15:0] r_shift_out,  n_shift_out;
    logic [7:0]  r_read_accum, n_read_accum;
    logic        r_read_mode,  n_read_mode;
    logic        r_clock_half, n_clock_half;

    logic        done;
    logic [7:0]  rv;
    logic [4:0]  bit_inc;
    logic [4:0]  send_bits;

    assign bit_inc   = r_bit_index + 5'd1;
    assign send_bits = r_read_mode ? twrtc_pkg::SEND_BITS_READ : twrtc_pkg::SEND_BITS_WRITE;

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift_out  = r_shift_out;
        n_read_accum = r_read_accum;
        n_read_mode  = r_read_mode;
        n_clock_half = r_clock_half;
        done         = 1'b0;
        rv           = 8'd0;
        if (i_step) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req.req_type == twrtc_pkg::REQ_WRITE ||
                        i_req.req_type == twrtc_pkg::REQ_READ) begin
                        if (i_req.req_type == twrtc_pkg::REQ_WRITE) begin
                            n_shift_out = {twrtc_pkg::to_bcd(i_req.write_value), i_req.reg_addr};
                            n_read_mode = 1'b0;
                        end else begin
                            n_shift_out = {8'h00, i_req.reg_addr + twrtc_pkg::READ_INCR};
                            n_read_mode = 1'b1;
                        end
                        n_phase      = PH_SEND;
                        n_bit_index  = 5'd0;
                        n_clock_half = 1'b0;
                        n_read_accum = 8'd0;
                    end
                end
                PH_SEND: begin
                    if (i_req.req_type == twrtc_pkg::REQ_TICK) begin
                        if (!r_clock_half) begin
                            n_clock_half = 1'b1;
                        end else begin
                            n_clock_half = 1'b0;
                            n_bit_index  = bit_inc;
                            if (bit_inc >= send_bits) begin
                                n_bit_index = 5'd0;
                                if (r_read_mode) begin
                                    n_phase = PH_RECV;
                                end else begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_RECV: begin
                    if (i_req.req_type == twrtc_pkg::REQ_TICK) begin
                        if (!r_clock_half) begin
                            n_read_accum = r_read_accum |
                                ({7'd0, i_req.io_in} << r_bit_index[2:0]);
                            if (r_bit_index >= twrtc_pkg::RECV_LAST_BIT) begin
                                n_phase     = PH_IDLE;
                                n_bit_index = 5'd0;
                                done        = 1'b1;
                                rv          = twrtc_pkg::from_bcd(n_read_accum);
                            end else begin
                                n_clock_half = 1'b1;
                            end
                        end else begin
                            n_clock_half = 1'b0;
                            n_bit_index  = bit_inc;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Line levels after this beat, taken from the next state.
    always_comb begin
        o_res.chip_enable  = (n_phase != PH_IDLE);
        o_res.serial_clock = n_clock_half;
        o_res.data_out     = (n_phase == PH_SEND) ? n_shift_out[n_bit_index[3:0]] : 1'b0;
        o_res.data_drive   = (n_phase != PH_RECV);
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = done;
        o_res.read_value   = rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= 5'd0;
            r_shift_out  <= 16'd0;
            r_read_accum <= 8'd0;
            r_read_mode  <= 1'b0;
            r_clock_half <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_shift_out  <= n_shift_out;
            r_read_accum <= n_read_accum;
            r_read_mode  <= n_read_mode;
            r_clock_half <= n_clock_half;
        end
    end

`ifndef SYNTHESIS
    a_recv_is_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> r_read_mode)
        else $error("receive phase entered by a write transaction");
    a_recv_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> r_bit_index < twrtc_pkg::SEND_BITS_READ)
        else $error("receive bit index out of range");
    a_send_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SEND |-> r_bit_index < send_bits)
        else $error("send bit index out of range");
    a_idle_clock_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> !r_clock_half)
        else $error("serial clock left high while idle");
`endif

endmodule

// ----- tb/twrtc_link_checker.sv -----
// Checker for the three-wire RTC serial master: watches both stream channels, predicts
// the line levels for every accepted beat and compares them with the output beats.
// Depends on twrtc_pkg for the request codes and bit counts.
`timescale 1ns / 1ps

module twrtc_link_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,  // reg_addr[7:0], write_value[14:8], io_in[15]
    input  logic [1:0]  i_s_tuser,  // req_type[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,  // chip_enable, serial_clock, data_out, data_drive,
                                    // busy_res, done_res, read_value[13:6], zero[15:14]
    output int          o_errors,
    output int          o_pending
);

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_SEND,
        LINK_RECV
    } t_link_phase;

    localparam int SHOWN_ERRORS = 40;

    t_link_phase link_phase;
    logic [4:0]  bit_pos;
    logic [15:0] tx_bits;
    logic [7:0]  rx_byte;
    logic        is_read;
    logic        clk_high;

    twrtc_pkg::t_res expected_lines[$];
    int   err_count;
    int   pend_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pend_count;

    // Decimal to BCD, saturating at 99.
    function automatic logic [7:0] encode_bcd(input logic [6:0] value);
        int sat;
        sat = (value > 7'd99) ? 99 : int'(value);
        return {4'(sat / 10), 4'(sat % 10)};
    endfunction

    // Advances the link model by one beat and returns the line levels after it.
    function twrtc_pkg::t_res step_link(input twrtc_pkg::t_req rq);
        twrtc_pkg::t_res lines;
        logic done;
        logic [7:0] value;
        done  = 1'b0;
        value = '0;
        if (link_phase == LINK_IDLE) begin
            if (rq.req_type == twrtc_pkg::REQ_WRITE || rq.req_type == twrtc_pkg::REQ_READ) begin
                is_read  = (rq.req_type == twrtc_pkg::REQ_READ);
                tx_bits  = is_read ? {8'h00, rq.reg_addr + twrtc_pkg::READ_INCR}
                                   : {encode_bcd(rq.write_value), rq.reg_addr};
                link_phase = LINK_SEND;
                bit_pos  = '0;
                clk_high = 1'b0;
                rx_byte  = '0;
            end
        end else if (rq.req_type == twrtc_pkg::REQ_TICK) begin
            if (link_phase == LINK_SEND) begin
                if (!clk_high) begin
                    clk_high = 1'b1;
                end else begin
                    clk_high = 1'b0;
                    bit_pos  = bit_pos + 5'd1;
                    if (bit_pos >= (is_read ? twrtc_pkg::SEND_BITS_READ
                                            : twrtc_pkg::SEND_BITS_WRITE)) begin
                        bit_pos = '0;
                        if (is_read) begin
                            link_phase = LINK_RECV;
                        end else begin
                            link_phase = LINK_IDLE;
                            done = 1'b1;
                        end
                    end
                end
            end else begin
                if (!clk_high) begin
                    if (rq.io_in) rx_byte[bit_pos[2:0]] = 1'b1;
                    if (bit_pos >= twrtc_pkg::RECV_LAST_BIT) begin
                        link_phase = LINK_IDLE;
                        bit_pos = '0;
                        done  = 1'b1;
                        value = 8'(int'(rx_byte[7:4]) * 10 + int'(rx_byte[3:0]));
                    end else begin
                        clk_high = 1'b1;
                    end
                end else begin
                    clk_high = 1'b0;
                    bit_pos  = bit_pos + 5'd1;
                end
            end
        end
        lines.chip_enable  = (link_phase != LINK_IDLE);
        lines.serial_clock = clk_high;
        lines.data_out     = (link_phase == LINK_SEND && bit_pos < 5'd16) ?
                             tx_bits[bit_pos[3:0]] : 1'b0;
        lines.data_drive   = (link_phase != LINK_RECV);
        lines.busy_res     = (link_phase != LINK_IDLE);
        lines.done_res     = done;
        lines.read_value   = value;
        return lines;
    endfunction

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            if (err_count < SHOWN_ERRORS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        twrtc_pkg::t_res want;
        twrtc_pkg::t_req rq;
        if (!i_rst_n) begin
            link_phase = LINK_IDLE;
            bit_pos  = '0;
            tx_bits  = '0;
            rx_byte  = '0;
            is_read  = 1'b0;
            clk_high = 1'b0;
            expected_lines.delete();
            err_count = 0;
        end else begin
            // Output beats are matched before the new input beat is queued, since an
            // output can never belong to a beat accepted at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_lines.size() == 0) begin
                    if (err_count < SHOWN_ERRORS)
                        $display("%0t: unexpected output beat: expected none, actual %h",
                                 $time, i_m_tdata);
                    err_count++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("chip_enable", want.chip_enable, i_m_tdata[0]);
                    check_field("serial_clock", want.serial_clock, i_m_tdata[1]);
                    check_field("data_out", want.data_out, i_m_tdata[2]);
                    check_field("data_drive", want.data_drive, i_m_tdata[3]);
                    check_field("busy_res", want.busy_res, i_m_tdata[4]);
                    check_field("done_res", want.done_res, i_m_tdata[5]);
                    check_field("read_value", want.read_value, i_m_tdata[13:6]);
                    check_field("padding", 0, i_m_tdata[15:14]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                rq.req_type    = i_s_tuser;
                rq.reg_addr    = i_s_tdata[7:0];
                rq.write_value = i_s_tdata[14:8];
                rq.io_in       = i_s_tdata[15];
                expected_lines.push_back(step_link(rq));
            end
        end
        pend_count = expected_lines.size();
    end

endmodule

// ----- tb/tb_three_wire_rtc_serial_master.sv -----
// Testbench top for the three-wire RTC serial master: clock, reset, beat stimulus and verdict.
// Depends on twrtc_pkg, three_wire_rtc_serial_master and twrtc_link_checker.
`timescale 1ns / 1ps

module tb_three_wire_rtc_serial_master;

    // Request code 3 is not defined by the block; it must be ignored everywhere.
    localparam logic [1:0] REQ_NONE = 2'd3;

    // A write shifts 16 bits with two ticks each. A read shifts 8 bits out,
    // then samples 8 bits where the last bit takes one tick instead of two.
    localparam int WRITE_TICKS = 32;
    localparam int READ_TICKS  = 31;

    localparam int RANDOM_BEATS  = 1950;
    localparam int IDLE_PERCENT  = 8;
    localparam int CALM_FIRST    = 700;
    localparam int CALM_LAST     = 1100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // reg_addr[7:0], write_value[14:8], io_in[15]
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // chip_enable, serial_clock, data_out, data_drive,
                            // busy_res, done_res, read_value[13:6], zero[15:14]

    int          errors;
    int          pending;
    int          beats_sent = 0;
    bit          calm = 1'b0;
    int unsigned cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    three_wire_rtc_serial_master dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    twrtc_link_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // The receiver stalls now and then, except during the calm stretch in the
    // middle of the random part where both sides run at full rate.
    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost output beat ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Presents one beat from a falling edge on and holds it until the rising
    // edge at which the block accepts it. Sometimes the sender idles first,
    // with tvalid low. Inputs sampled right after the rising edge still hold
    // their values from before it.
    task automatic send_beat(input logic [1:0] req, input logic [7:0] addr,
                             input logic [6:0] value, input logic io);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {io, value, addr};
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // One transaction: a start beat followed by the ticks that carry it to the
    // end. The command byte and the value often sit at their extremes, and the
    // sampled data line is all ones, all zeros or random for the whole read.
    // A few transfers are cut short, so that the next start lands while busy
    // and its ticks keep driving the old transfer; a few get spare ticks that
    // arrive while idle. Now and then a stray write, read or undefined request
    // is slipped in before a tick; it is ignored while the link is busy.
    task automatic run_transfer();
        logic [7:0] addr;
        logic [6:0] value;
        logic       io;
        logic [1:0] noise;
        bit         is_read;
        int         io_mode;
        int         ticks;
        is_read = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: addr = 8'h00;
            1: addr = 8'hFF;
            default: addr = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0: value = 7'd0;
            1: value = 7'd99;
            2: value = 7'($urandom_range(100, 127));
            default: value = 7'($urandom_range(0, 99));
        endcase
        io_mode = int'($urandom_range(0, 3));
        ticks = is_read ? READ_TICKS : WRITE_TICKS;
        if ($urandom_range(0, 19) == 0)
            ticks = int'($urandom_range(0, ticks - 1));
        else if ($urandom_range(0, 9) == 0)
            ticks += int'($urandom_range(1, 3));

        send_beat(is_read ? twrtc_pkg::REQ_READ : twrtc_pkg::REQ_WRITE, addr, value,
                  1'($urandom_range(0, 1)));
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 99) < 6) begin
                case ($urandom_range(0, 2))
                    0: noise = twrtc_pkg::REQ_WRITE;
                    1: noise = twrtc_pkg::REQ_READ;
                    default: noise = REQ_NONE;
                endcase
                send_beat(noise, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)));
            end
            case (io_mode)
                0: io = 1'b1;
                1: io = 1'b0;
                default: io = 1'($urandom_range(0, 1));
            endcase
            send_beat(twrtc_pkg::REQ_TICK, 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)), io);
        end
        calm = (beats_sent >= CALM_FIRST && beats_sent < CALM_LAST);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = twrtc_pkg::REQ_TICK;
        s_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A tick and an undefined request while idle must do
        // nothing. The write carries the largest value the field can hold, which
        // must saturate to 99 in BCD, at the top command byte. Requests made
        // while the write runs are ignored and do not move the transfer.
        send_beat(twrtc_pkg::REQ_TICK, 8'h00, 7'd0, 1'b1);
        send_beat(REQ_NONE, 8'hFF, 7'd127, 1'b1);
        send_beat(twrtc_pkg::REQ_WRITE, 8'hFF, 7'd127, 1'b0);
        send_beat(twrtc_pkg::REQ_READ, 8'hFF, 7'd0, 1'b1);
        send_beat(REQ_NONE, 8'h00, 7'd0, 1'b0);
        for (int k = 0; k < WRITE_TICKS; k++)
            send_beat(twrtc_pkg::REQ_TICK, 8'h5A, 7'h2A, k[0]);

        // Random part: mostly whole transfers with random content.
        while (beats_sent < RANDOM_BEATS)
            run_transfer();
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Every input beat yields one output beat.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/twrtc_pkg.sv
hw/rtl/twrtc_core.sv
hw/rtl/three_wire_rtc_serial_master.sv
tb/twrtc_link_checker.sv
tb/tb_three_wire_rtc_serial_master.sv
